@@ sv/assert_macros.svh @@
// shared assertion macros, clocked on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that holds on every clock edge
`define BSR_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define BSR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BSR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/bsr_pkg.sv @@
package bsr_pkg;

    // frame geometry
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int DIM_W      = 11;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int PIX_W      = 8;

    // result fields
    localparam int AREA_W  = 21;
    localparam int PERIM_W = 23;
    localparam int QUO_W   = 18;
    localparam int FRAC_W  = 16;

    // roundness datapath: N = A*K + P^2 * 2^15, D = P^2 * 2^16
    localparam int K_W         = 36;
    localparam int ROUND_SHIFT = FRAC_W - 1;
    localparam int SQ_W        = 2 * PERIM_W;
    localparam int NUM_W       = SQ_W + FRAC_W;
    localparam int DIV_STEPS   = QUO_W + 1;
    localparam int DIV_SHIFT   = FRAC_W + QUO_W;
    localparam int ACC_W       = SQ_W + DIV_SHIFT;
    localparam int CNT_W       = $clog2(PERIM_W);

    // configuration port
    localparam int CFG_IDX_W = 2;

    typedef logic [COL_W-1:0]     col_t;
    typedef logic [ROW_W-1:0]     row_t;
    typedef logic [DIM_W-1:0]     dim_t;
    typedef logic [PIX_W-1:0]     pix_t;
    typedef logic [AREA_W-1:0]    area_t;
    typedef logic [PERIM_W-1:0]   perim_t;
    typedef logic [PERIM_W:0]     perim_sum_t;
    typedef logic [SQ_W-1:0]      sq_t;
    typedef logic [NUM_W-1:0]     num_t;
    typedef logic [ACC_W-1:0]     acc_t;
    typedef logic [ACC_W:0]       sum_t;
    typedef logic [CNT_W-1:0]     cnt_t;
    typedef logic [DIV_STEPS-1:0] quo_t;
    typedef logic [QUO_W-1:0]     rnd_t;
    typedef logic [K_W-1:0]       k_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // 4*pi rounded to 32 fraction bits
    localparam k_t FOUR_PI_Q32 = 36'hC90FDAA22;

    localparam area_t  AREA_MAX  = '1;
    localparam perim_t PERIM_MAX = '1;

    // register indexes
    localparam cfg_idx_t REG_FRAME_WIDTH  = 2'd0;
    localparam cfg_idx_t REG_FRAME_HEIGHT = 2'd1;

    localparam dim_t RESET_WIDTH  = 11'd640;
    localparam dim_t RESET_HEIGHT = 11'd480;

    // handshake between frame counter and roundness unit
    typedef struct packed {
        logic busy;
        logic done;
    } bsr_status_t;

    typedef struct packed {
        area_t  area;
        perim_t perim;
        rnd_t   roundness;
        logic   zero;
    } bsr_result_t;

endpackage

@@ sv/bsr_ram.sv @@
module bsr_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // single write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read, old data on a same-address write
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/bsr_ratio.sv @@
`include "assert_macros.svh"

module bsr_ratio (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  bsr_pkg::area_t       area,
    input  bsr_pkg::perim_t      perim,
    input  logic                 take,
    output bsr_pkg::bsr_status_t status,
    output bsr_pkg::bsr_result_t result
);

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_SQUARE  = 5'b00010,
        ST_PRODUCT = 5'b00100,
        ST_DIVIDE  = 5'b01000,
        ST_DONE    = 5'b10000
    } bsr_state_t;

    bsr_state_t      state_reg, state_next;
    bsr_pkg::cnt_t   cnt_reg, cnt_next;
    bsr_pkg::acc_t   mcand_reg, mcand_next;
    bsr_pkg::perim_t mplier_reg, mplier_next;
    bsr_pkg::sq_t    sq_reg, sq_next, sq_upd;
    bsr_pkg::num_t   num_reg, num_next;
    bsr_pkg::quo_t   quo_reg, quo_next;
    bsr_pkg::area_t  area_hold_reg, area_hold_next;
    bsr_pkg::perim_t perim_hold_reg, perim_hold_next;

    bsr_pkg::acc_t   op_a, op_b;
    bsr_pkg::sum_t   sum;
    logic            sub;
    logic            ge;

    // shared adder / subtractor: shift-add multiply and restoring divide
    assign sub  = (state_reg == ST_DIVIDE);
    assign op_a = (state_reg == ST_SQUARE) ? bsr_pkg::acc_t'(sq_reg)
                                           : bsr_pkg::acc_t'(num_reg);
    assign op_b = sub ? ~mcand_reg : mcand_reg;
    assign sum  = {1'b0, op_a} + {1'b0, op_b} + bsr_pkg::sum_t'(sub);
    assign ge   = sum[bsr_pkg::ACC_W];

    assign sq_upd = mplier_reg[0] ? bsr_pkg::sq_t'(sum) : sq_reg;

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        mcand_next      = mcand_reg;
        mplier_next     = mplier_reg;
        sq_next         = sq_reg;
        num_next        = num_reg;
        quo_next        = quo_reg;
        area_hold_next  = area_hold_reg;
        perim_hold_next = perim_hold_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    area_hold_next  = area;
                    perim_hold_next = perim;
                    sq_next         = '0;
                    mcand_next      = bsr_pkg::acc_t'(perim);
                    mplier_next     = perim;
                    cnt_next        = bsr_pkg::cnt_t'(bsr_pkg::PERIM_W - 1);
                    state_next      = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                // P*P, one multiplier bit per cycle
                sq_next     = sq_upd;
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    // numerator starts with the rounding term D/2
                    num_next    = bsr_pkg::num_t'(sq_upd) << bsr_pkg::ROUND_SHIFT;
                    mcand_next  = bsr_pkg::acc_t'(bsr_pkg::FOUR_PI_Q32);
                    mplier_next = bsr_pkg::perim_t'(area_hold_reg);
                    cnt_next    = bsr_pkg::cnt_t'(bsr_pkg::AREA_W - 1);
                    state_next  = ST_PRODUCT;
                end
            end
            ST_PRODUCT:
            begin
                // accumulate A*K onto the numerator
                if (mplier_reg[0])
                begin
                    num_next = bsr_pkg::num_t'(sum);
                end
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    mcand_next = bsr_pkg::acc_t'(sq_reg) << bsr_pkg::DIV_SHIFT;
                    quo_next   = '0;
                    cnt_next   = bsr_pkg::cnt_t'(bsr_pkg::DIV_STEPS - 1);
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                // restoring division, top quotient bit flags saturation
                if (ge)
                begin
                    num_next = bsr_pkg::num_t'(sum);
                end
                quo_next   = {quo_reg[bsr_pkg::DIV_STEPS-2:0], ge};
                mcand_next = mcand_reg >> 1;
                cnt_next   = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg        <= cnt_next;
        mcand_reg      <= mcand_next;
        mplier_reg     <= mplier_next;
        sq_reg         <= sq_next;
        num_reg        <= num_next;
        quo_reg        <= quo_next;
        area_hold_reg  <= area_hold_next;
        perim_hold_reg <= perim_hold_next;
    end

    // result and status
    assign status.busy      = (state_reg != ST_IDLE);
    assign status.done      = (state_reg == ST_DONE);
    assign result.area      = area_hold_reg;
    assign result.perim     = perim_hold_reg;
    assign result.zero      = (perim_hold_reg == '0);
    assign result.roundness = result.zero ? '0 :
                              quo_reg[bsr_pkg::DIV_STEPS-1] ? '1 :
                              quo_reg[bsr_pkg::QUO_W-1:0];

    `BSR_ASSERT_IMP(a_start_idle, start, state_reg == ST_IDLE, "start while roundness unit busy")
    `BSR_ASSERT_NXT(a_div_done, (state_reg == ST_DIVIDE) && (cnt_reg == '0), state_reg == ST_DONE, "division did not finish")
    `BSR_ASSERT_NXT(a_done_hold, (state_reg == ST_DONE) && !take, (state_reg == ST_DONE) && $stable(result), "result lost before taken")

endmodule

@@ sv/binary_shape_roundness.sv @@
// Binary shape roundness. Pixels of a frame_width x frame_height frame enter in row order,
// one per clock while in_stall is low; a nonzero pixel is foreground. Area and the count
// of differing 4-neighbour pairs accumulate as the frame streams, using a one-row flag
// memory. After the last pixel of a frame the block raises in_stall while it forms P*P,
// then A*4pi, then the division, and hands off the result; one shared 80-bit
// adder/subtractor computes roundness 4*pi*A/P^2 as unsigned Q2.16, rounded to nearest
// and saturated; in_stall stays high longer only if the previous result still waits in
// the output register. A frame with zero perimeter reports roundness 0 with
// zero_perimeter set. Writing frame_width or frame_height restarts the frame; a
// dimension of 0 acts as 1 and one above 1024 acts as 1024.
`include "assert_macros.svh"

module binary_shape_roundness (
    input  logic                     clk,
    input  logic                     rst_n,
    // pixel stream
    input  logic                     in_valid,
    output logic                     in_stall,
    input  bsr_pkg::pix_t            pixel_value,
    // result stream
    output logic                     out_valid,
    input  logic                     out_stall,
    output bsr_pkg::area_t           area_count,
    output bsr_pkg::perim_t          perimeter_count,
    output bsr_pkg::rnd_t            roundness_q16,
    output logic                     zero_perimeter,
    // configuration
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  bsr_pkg::cfg_idx_t        cfg_index,
    input  bsr_pkg::dim_t            cfg_data
);

    bsr_pkg::dim_t       width_cfg_reg, width_cfg_next;
    bsr_pkg::dim_t       height_cfg_reg, height_cfg_next;
    bsr_pkg::col_t       col_reg, col_next, last_col;
    bsr_pkg::row_t       row_reg, row_next, last_row;
    logic                left_reg, left_next;
    bsr_pkg::area_t      area_reg, area_next, area_upd;
    bsr_pkg::perim_t     perim_reg, perim_next, perim_upd;
    bsr_pkg::perim_sum_t perim_sum;
    logic                byp_hit_reg, byp_hit_next;
    logic                byp_data_reg;
    logic                out_valid_reg, out_valid_next;
    bsr_pkg::bsr_result_t out_data_reg;

    logic                in_acc, cfg_wr, cfg_hit;
    logic                fg, above, ram_rdata;
    logic                edge_left, edge_up;
    logic                end_col, end_row, frame_end;
    logic                take;
    bsr_pkg::bsr_status_t ratio_status;
    bsr_pkg::bsr_result_t ratio_result;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign cfg_hit   = cfg_wr && ((cfg_index == bsr_pkg::REG_FRAME_WIDTH) ||
                                  (cfg_index == bsr_pkg::REG_FRAME_HEIGHT));
    assign in_stall  = ratio_status.busy;
    assign in_acc    = in_valid && !in_stall;

    // configuration registers
    always_comb
    begin
        width_cfg_next  = width_cfg_reg;
        height_cfg_next = height_cfg_reg;
        if (cfg_wr && (cfg_index == bsr_pkg::REG_FRAME_WIDTH))
        begin
            width_cfg_next = cfg_data;
        end
        if (cfg_wr && (cfg_index == bsr_pkg::REG_FRAME_HEIGHT))
        begin
            height_cfg_next = cfg_data;
        end
    end

    // clamped last column and row
    always_comb
    begin
        if (width_cfg_reg == '0)
        begin
            last_col = '0;
        end
        else if (32'(width_cfg_reg) > bsr_pkg::MAX_WIDTH)
        begin
            last_col = bsr_pkg::col_t'(bsr_pkg::MAX_WIDTH - 1);
        end
        else
        begin
            last_col = bsr_pkg::col_t'(width_cfg_reg - 1'b1);
        end
        if (height_cfg_reg == '0)
        begin
            last_row = '0;
        end
        else if (32'(height_cfg_reg) > bsr_pkg::MAX_HEIGHT)
        begin
            last_row = bsr_pkg::row_t'(bsr_pkg::MAX_HEIGHT - 1);
        end
        else
        begin
            last_row = bsr_pkg::row_t'(height_cfg_reg - 1'b1);
        end
    end

    // neighbour tests against left pixel and row above
    assign fg        = (pixel_value != '0);
    assign above     = byp_hit_reg ? byp_data_reg : ram_rdata;
    assign edge_left = (col_reg != '0) && (fg != left_reg);
    assign edge_up   = (row_reg != '0) && (fg != above);

    // saturating counters
    assign perim_sum = {1'b0, perim_reg} + bsr_pkg::perim_sum_t'(edge_left)
                                         + bsr_pkg::perim_sum_t'(edge_up);
    assign perim_upd = perim_sum[bsr_pkg::PERIM_W] ? bsr_pkg::PERIM_MAX
                                                   : perim_sum[bsr_pkg::PERIM_W-1:0];
    assign area_upd  = (fg && (area_reg != bsr_pkg::AREA_MAX)) ? area_reg + 1'b1 : area_reg;

    assign end_col   = (col_reg == last_col);
    assign end_row   = (row_reg == last_row);
    assign frame_end = in_acc && end_col && end_row;

    // raster position and running counts
    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        left_next  = left_reg;
        area_next  = area_reg;
        perim_next = perim_reg;
        if (cfg_hit)
        begin
            col_next   = '0;
            row_next   = '0;
            left_next  = 1'b0;
            area_next  = '0;
            perim_next = '0;
        end
        else if (in_acc)
        begin
            left_next  = fg;
            area_next  = area_upd;
            perim_next = perim_upd;
            if (end_col)
            begin
                col_next = '0;
                row_next = end_row ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
            if (frame_end)
            begin
                left_next  = 1'b0;
                area_next  = '0;
                perim_next = '0;
            end
        end
    end

    // one-pixel-wide rows read the entry being written
    assign byp_hit_next = in_acc && (col_next == col_reg);

    bsr_ram #(
        .WIDTH (1),
        .DEPTH (bsr_pkg::MAX_WIDTH)
    ) u_row_flags (
        .clk   (clk),
        .we    (in_acc),
        .waddr (col_reg),
        .wdata (fg),
        .raddr (col_next),
        .rdata (ram_rdata)
    );

    bsr_ratio u_ratio (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (frame_end),
        .area   (area_upd),
        .perim  (perim_upd),
        .take   (take),
        .status (ratio_status),
        .result (ratio_result)
    );

    // output register
    assign take = ratio_status.done && (!out_valid_reg || !out_stall);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg  <= bsr_pkg::RESET_WIDTH;
            height_cfg_reg <= bsr_pkg::RESET_HEIGHT;
            col_reg        <= '0;
            row_reg        <= '0;
            left_reg       <= 1'b0;
            area_reg       <= '0;
            perim_reg      <= '0;
            byp_hit_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            width_cfg_reg  <= width_cfg_next;
            height_cfg_reg <= height_cfg_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            left_reg       <= left_next;
            area_reg       <= area_next;
            perim_reg      <= perim_next;
            byp_hit_reg    <= byp_hit_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byp_data_reg <= fg;
        if (take)
        begin
            out_data_reg <= ratio_result;
        end
    end

    assign out_valid       = out_valid_reg;
    assign area_count      = out_data_reg.area;
    assign perimeter_count = out_data_reg.perim;
    assign roundness_q16   = out_data_reg.roundness;
    assign zero_perimeter  = out_data_reg.zero;

    `BSR_ASSERT_NXT(a_frame_end_stall, frame_end, in_stall, "no stall after last pixel of frame")
    `BSR_ASSERT_IMP(a_zero_round, out_valid && zero_perimeter, roundness_q16 == '0, "nonzero roundness with zero perimeter")
    `BSR_ASSERT(a_col_range, col_reg <= last_col, "column beyond frame width")

endmodule
